// ===== rtl/mwvc_pkg.sv =====
// Package for the moving-window valid count core.
// Holds the configuration layout, register index codes, the command passed from the
// front end to the back end, and the result layout. No dependencies.
`default_nettype none

package mwvc_pkg;

	// Largest window the flag shift register can hold
	localparam int MAX_WINDOW_DEF = 32;

	// Depth of the command queue between the front and back ends
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam logic [2:0] REG_WINDOW_SIZE    = 3'd0;
	localparam logic [2:0] REG_STEP_SIZE      = 3'd1;
	localparam logic [2:0] REG_REMOVE_MISSING = 3'd2;
	localparam logic [2:0] REG_REDUCED_OUTPUT = 3'd3;
	localparam logic [2:0] REG_ALIGNMENT      = 3'd4;

	// Window alignment codes; any other code places the window right
	localparam logic [1:0] ALIGN_LEFT   = 2'd0;
	localparam logic [1:0] ALIGN_MIDDLE = 2'd1;

	typedef struct packed {
		logic [5:0]  window_size;
		logic [15:0] step_size;
		logic        remove_missing;
		logic        reduced_output;
		logic [1:0]  alignment;
	} cfg_t;

	// Per-item facts carried down the front pipeline beside the popcount
	typedef struct packed {
		logic [5:0] n;          // clamped window size
		logic [5:0] seen_n;     // min(samples seen, n)
		logic       ongrid;
		logic       emit_main;
		logic       fin;
		logic [5:0] flush;      // trailing NA positions to flush
		logic       remove_missing;
		logic       reduced;
	} tag_t;

	// Classified item handed to the back end
	typedef struct packed {
		logic [5:0] cnt;
		logic       na;
		logic       ongrid;
		logic       emit_main;
		logic       fin;
		logic [5:0] flush;
		logic       reduced;
	} cmd_t;

	// One result item
	typedef struct packed {
		logic [5:0] cnt;
		logic       na;
		logic       empty;
		logic       last;
	} res_t;

endpackage

`default_nettype wire

// ===== rtl/mwvc_front.sv =====
// Front end of the moving-window valid count core: accepts samples, keeps the flag
// window, sample counter and grid phase, and counts missing flags in a registered tree.
// Depends on mwvc_pkg.
`default_nettype none

module mwvc_front #(
	parameter int MAX_WINDOW = mwvc_pkg::MAX_WINDOW_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mwvc_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_missing,
	input  logic          in_final,
	output logic          push,
	output mwvc_pkg::cmd_t push_cmd,
	input  logic          q_ready
);
	import mwvc_pkg::*;

	localparam int MW = MAX_WINDOW;
	localparam int NG = (MW + 7) / 8;
	localparam logic [6:0] MW7 = 7'(MW);

	// stream state
	logic [MW-1:0] window_q;
	logic [31:0]   seen_q;
	logic [15:0]   phase_q;

	// pipeline
	logic          v_s1, v_s2, v_s3;
	logic [MW-1:0] masked_s1;
	tag_t          tag_s1, tag_s2, tag_s3;
	logic [3:0]    grp_s2 [NG];
	logic [5:0]    missing_s3;

	logic          pipe_en, accept;
	logic [5:0]    n, p, d, flush;
	logic [31:0]   seen_nx;
	logic          full, ongrid, emit_main;
	logic [15:0]   ss, ph, ph_next;
	logic [16:0]   ph_inc;
	logic [MW:0]   win_cat;
	logic [MW-1:0] win_nx, mask;
	logic [3:0]    grp_c [NG];
	logic [6:0]    miss_sum;
	logic [5:0]    present;

	// whole pipeline advances together; stalls only when the last stage cannot push
	assign pipe_en  = !v_s3 || q_ready;
	assign in_ready = pipe_en;
	assign accept   = in_valid && pipe_en;

	// classify the incoming sample
	always_comb begin
		if (cfg.window_size == '0)
			n = 6'd1;
		else if ({1'b0, cfg.window_size} > MW7)
			n = MW7[5:0];
		else
			n = cfg.window_size;

		unique case (cfg.alignment)
			ALIGN_LEFT:   p = '0;
			ALIGN_MIDDLE: p = n >> 1;
			default:      p = n - 6'd1;
		endcase
		d = n - 6'd1 - p;

		seen_nx = (seen_q == '1) ? seen_q : seen_q + 32'd1;
		full    = seen_nx >= {26'd0, n};

		ss      = (cfg.step_size == '0) ? 16'd1 : cfg.step_size;
		ph      = (phase_q >= ss) ? 16'd0 : phase_q;
		ph_inc  = {1'b0, ph} + 17'd1;
		ph_next = (ph_inc >= {1'b0, ss}) ? 16'd0 : ph_inc[15:0];
		ongrid  = full && (ph == '0);

		emit_main = seen_nx > {26'd0, d};
		if (!in_final)
			flush = '0;
		else if (seen_nx < {26'd0, d})
			flush = seen_nx[5:0];
		else
			flush = d;

		win_cat = {window_q, in_missing};
		win_nx  = win_cat[MW-1:0];
		for (int i = 0; i < MW; i++)
			mask[i] = 7'(i) < {1'b0, n};
	end

	// stream state; cleared after the last sample of a vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
			phase_q  <= '0;
		end else if (accept) begin
			if (in_final) begin
				window_q <= '0;
				seen_q   <= '0;
				phase_q  <= '0;
			end else begin
				window_q <= win_nx;
				seen_q   <= seen_nx;
				if (full)
					phase_q <= ph_next;
			end
		end
	end

	// group popcounts of the masked window
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_c[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (g * 8 + b < MW)
					grp_c[g] = grp_c[g] + 4'(masked_s1[g * 8 + b]);
			end
		end
		miss_sum = '0;
		for (int g = 0; g < NG; g++)
			miss_sum = miss_sum + 7'(grp_s2[g]);
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			masked_s1             <= win_nx & mask;
			tag_s1.n              <= n;
			tag_s1.seen_n         <= full ? n : seen_nx[5:0];
			tag_s1.ongrid         <= ongrid;
			tag_s1.emit_main      <= emit_main;
			tag_s1.fin            <= in_final;
			tag_s1.flush          <= flush;
			tag_s1.remove_missing <= cfg.remove_missing;
			tag_s1.reduced        <= cfg.reduced_output;
			grp_s2                <= grp_c;
			tag_s2                <= tag_s1;
			missing_s3            <= miss_sum[5:0];
			tag_s3                <= tag_s2;
		end
	end

	// final count and NA decision
	always_comb begin
		present = (tag_s3.seen_n >= missing_s3) ? tag_s3.seen_n - missing_s3 : 6'd0;
		push_cmd.ongrid    = tag_s3.ongrid;
		push_cmd.emit_main = tag_s3.emit_main;
		push_cmd.fin       = tag_s3.fin;
		push_cmd.flush     = tag_s3.flush;
		push_cmd.reduced   = tag_s3.reduced;
		if (tag_s3.remove_missing) begin
			push_cmd.cnt = present;
			push_cmd.na  = 1'b0;
		end else if (missing_s3 != '0) begin
			push_cmd.cnt = '0;
			push_cmd.na  = 1'b1;
		end else begin
			push_cmd.cnt = tag_s3.n;
			push_cmd.na  = 1'b0;
		end
	end

	assign push = v_s3 && q_ready;

endmodule

`default_nettype wire

// ===== rtl/mwvc_queue.sv =====
// Command queue between the front and back ends of the moving-window valid count core.
// Small register FIFO with a combinational head. Depends on mwvc_pkg.
`default_nettype none

module mwvc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mwvc_pkg::cmd_t push_cmd,
	output logic           q_ready,
	output logic           q_valid,
	output mwvc_pkg::cmd_t head,
	input  logic           pop
);
	import mwvc_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [PW-1:0] PTR_ONE  = PW'(1);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign q_ready = count_q != FULL_CNT;
	assign q_valid = count_q != '0;
	assign head    = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_ONE;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_ONE;
			if (push && !pop)
				count_q <= count_q + CNT_ONE;
			else if (pop && !push)
				count_q <= count_q - CNT_ONE;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != FULL_CNT || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== rtl/mwvc_back.sv =====
// Back end of the moving-window valid count core: expands each command into its result
// items (grid result, held reduced result, trailing NA flush) through an output register.
// Depends on mwvc_pkg.
`default_nettype none

module mwvc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  mwvc_pkg::cmd_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output mwvc_pkg::res_t out_res
);
	import mwvc_pkg::*;

	// slots of the command being expanded
	logic       a_v_q, b_v_q;
	res_t       a_q, b_q;
	logic [5:0] tail_q;
	// held grid result for reduced mode
	logic       pend_v_q, pend_na_q;
	logic [5:0] pend_cnt_q;
	// output register
	logic       out_v_q;
	res_t       out_q;

	logic       busy, single, out_go, can_load;
	res_t       emit_res;
	logic       ld_a_v, ld_b_v;
	res_t       ld_a, ld_b;
	logic [5:0] ld_tail;
	logic       upd_v, upd_na, pend_nx_v;
	logic [5:0] upd_cnt;

	// sequencing
	always_comb begin
		busy   = a_v_q || b_v_q || (tail_q != '0);
		single = (a_v_q && !b_v_q && tail_q == '0) ||
		         (!a_v_q && b_v_q && tail_q == '0) ||
		         (!a_v_q && !b_v_q && tail_q == 6'd1);
		out_go   = busy && (!out_v_q || out_ready);
		can_load = !busy || (out_go && single);
		pop      = q_valid && can_load;

		if (a_v_q)
			emit_res = a_q;
		else if (b_v_q)
			emit_res = b_q;
		else
			emit_res = '{cnt: 6'd0, na: 1'b1, empty: 1'b0, last: (tail_q == 6'd1)};
	end

	// expansion of the head command
	always_comb begin
		upd_v   = head.ongrid || pend_v_q;
		upd_cnt = head.ongrid ? head.cnt : pend_cnt_q;
		upd_na  = head.ongrid ? head.na : pend_na_q;
		if (!head.reduced) begin
			ld_a_v  = head.emit_main;
			ld_a    = '{cnt: head.ongrid ? head.cnt : 6'd0,
			            na: head.ongrid ? head.na : 1'b1,
			            empty: 1'b0,
			            last: head.fin && (head.flush == '0)};
			ld_b_v  = 1'b0;
			ld_b    = '{cnt: 6'd0, na: 1'b0, empty: 1'b1, last: 1'b1};
			ld_tail = head.flush;
			pend_nx_v = pend_v_q && !head.fin;
		end else begin
			ld_a_v  = head.ongrid && pend_v_q;
			ld_a    = '{cnt: pend_cnt_q, na: pend_na_q, empty: 1'b0, last: 1'b0};
			ld_b_v  = head.fin;
			if (upd_v)
				ld_b = '{cnt: upd_cnt, na: upd_na, empty: 1'b0, last: 1'b1};
			else
				ld_b = '{cnt: 6'd0, na: 1'b0, empty: 1'b1, last: 1'b1};
			ld_tail   = '0;
			pend_nx_v = upd_v && !head.fin;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_v_q    <= 1'b0;
			b_v_q    <= 1'b0;
			tail_q   <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (pop) begin
				a_v_q    <= ld_a_v;
				b_v_q    <= ld_b_v;
				tail_q   <= ld_tail;
				pend_v_q <= pend_nx_v;
			end else if (out_go) begin
				if (a_v_q)
					a_v_q <= 1'b0;
				else if (b_v_q)
					b_v_q <= 1'b0;
				else
					tail_q <= tail_q - 6'd1;
			end
			if (out_go)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			a_q <= ld_a;
			b_q <= ld_b;
			if (head.reduced) begin
				pend_cnt_q <= upd_cnt;
				pend_na_q  <= upd_na;
			end
		end
		if (out_go)
			out_q <= emit_res;
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (!busy || (out_go && single)))
		else $error("command loaded over unfinished expansion");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.empty) |-> (out_q.last && out_q.cnt == '0 && !out_q.na))
		else $error("empty marker malformed");

endmodule

`default_nettype wire

// ===== rtl/moving_window_valid_count_core.sv =====
// Moving-window valid count core: one sample in per cycle, held off while the command
// queue is full and the last front stage holds an item. Results reach m_axis through the
// 3 front stages with the popcount tree, the command queue, the back end slots and the
// output register. Throughput: one result item per cycle while m_axis_tready allows; an
// item that flushes k trailing NA positions holds the queue until those results are out.
// Reset: config returns to defaults, stream state and queue clear at once; no sweep.
`default_nettype none

module moving_window_valid_count_core #(
	parameter int MAX_WINDOW = mwvc_pkg::MAX_WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// sample stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] sample_missing
	input  logic        s_axis_tlast,   // final_sample
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [5:0] valid_count
	output logic [1:0]  m_axis_tuser,   // [0] result_na, [1] empty_marker
	output logic        m_axis_tlast    // last_result
);
	import mwvc_pkg::*;

	cfg_t cfg_q;
	logic push, q_ready, q_valid, pop;
	cmd_t push_cmd, head;
	res_t out_res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{window_size: 6'd1, step_size: 16'd1, remove_missing: 1'b0,
			           reduced_output: 1'b0, alignment: 2'd0};
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WINDOW_SIZE:    cfg_q.window_size    <= cfg_data[5:0];
				REG_STEP_SIZE:      cfg_q.step_size      <= cfg_data;
				REG_REMOVE_MISSING: cfg_q.remove_missing <= cfg_data[0];
				REG_REDUCED_OUTPUT: cfg_q.reduced_output <= cfg_data[0];
				REG_ALIGNMENT:      cfg_q.alignment      <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	mwvc_front #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_missing(s_axis_tdata[0]),
		.in_final  (s_axis_tlast),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_ready   (q_ready)
	);

	mwvc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.q_ready (q_ready),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop)
	);

	mwvc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head     (head),
		.pop      (pop),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	assign m_axis_tdata = {2'b00, out_res.cnt};
	assign m_axis_tuser = {out_res.empty, out_res.na};
	assign m_axis_tlast = out_res.last;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for moving_window_valid_count_core.
// Holds a scoreboard class that predicts the result items of each sample item; uses
// mwvc_pkg for register indexes, alignment codes and the result layout.

module tb;

	import mwvc_pkg::*;

	localparam int MAX_WIN = MAX_WINDOW_DEF;
	// alignment codes not named in the package
	localparam logic [1:0] ALIGN_RIGHT = 2'd2;
	localparam logic [1:0] ALIGN_SPARE = 2'd3;
	// indexes past the last register are ignored by the block
	localparam int REG_COUNT = 5;
	localparam int REG_INDEX_SPAN = 8;
	// idle time before a config write or the end check: pipeline plus longest flush
	localparam int SETTLE_CYCLES = 48;
	localparam int RANDOM_ITEMS = 90;
	localparam int TIMEOUT = 5_000_000;

	// Predicts result items from accepted sample items and checks what comes out
	class window_count_board;
		logic [5:0]          win;
		logic [15:0]         step;
		logic                keep_count;
		logic                reduced;
		logic [1:0]          align;
		logic [MAX_WIN-1:0]  flags;
		int unsigned         seen;
		int unsigned         phase;
		bit                  held_valid;
		logic [5:0]          held_cnt;
		logic                held_na;
		res_t                expected[$];

		function new();
			win = 6'd1;
			step = 16'd1;
			keep_count = 1'b0;
			reduced = 1'b0;
			align = ALIGN_LEFT;
			clear_run();
		endfunction

		function void clear_run();
			flags = '0;
			seen = 0;
			phase = 0;
			held_valid = 0;
			held_cnt = '0;
			held_na = 1'b0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] val);
			case (idx)
				REG_WINDOW_SIZE:    win = val[5:0];
				REG_STEP_SIZE:      step = val;
				REG_REMOVE_MISSING: keep_count = val[0];
				REG_REDUCED_OUTPUT: reduced = val[0];
				REG_ALIGNMENT:      align = val[1:0];
				default: ;
			endcase
		endfunction

		function void push_res(int unsigned cnt, bit na, bit empty, bit last);
			res_t r;
			r.cnt = cnt[5:0];
			r.na = na;
			r.empty = empty;
			r.last = last;
			expected.push_back(r);
		endfunction

		// One accepted sample item: update the window and queue its result items
		function void note_sample(bit miss, bit fin);
			int unsigned n, ss, p, d, missing, seen_n, present, cnt, flush, j;
			bit na, ongrid, full;
			logic [63:0] mask;
			n = win;
			if (n < 1) n = 1;
			if (n > MAX_WIN) n = MAX_WIN;
			ss = step;
			if (ss < 1) ss = 1;
			if (align == ALIGN_LEFT) p = 0;
			else if (align == ALIGN_MIDDLE) p = n / 2;
			else p = n - 1;
			d = n - 1 - p;

			flags = {flags[MAX_WIN-2:0], miss};
			if (seen != 32'hFFFF_FFFF) seen++;
			mask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
			missing = $countones(64'(flags) & mask);
			seen_n = (seen < n) ? seen : n;
			present = (seen_n >= missing) ? seen_n - missing : 0;

			// grid position of this window start
			ongrid = 0;
			full = (seen >= n);
			if (full) begin
				if (phase >= ss) phase = 0;
				ongrid = (phase == 0);
				phase = (phase + 1 >= ss) ? 0 : phase + 1;
			end

			if (keep_count) begin
				cnt = present;
				na = 0;
			end else if (missing != 0) begin
				cnt = 0;
				na = 1;
			end else begin
				cnt = n;
				na = 0;
			end

			if (!reduced) begin
				if (seen > d) begin
					if (ongrid) push_res(cnt, na, 0, fin && d == 0);
					else push_res(0, 1, 0, fin && d == 0);
				end
				if (fin) begin
					flush = (seen < d) ? seen : d;
					for (j = 0; j < flush; j++) push_res(0, 1, 0, j + 1 == flush);
				end
			end else begin
				// grid results are held back one so the last can carry the end mark
				if (ongrid) begin
					if (held_valid) push_res(held_cnt, held_na, 0, 0);
					held_valid = 1;
					held_cnt = cnt[5:0];
					held_na = na;
				end
				if (fin) begin
					if (held_valid) push_res(held_cnt, held_na, 0, 1);
					else push_res(0, 0, 1, 1);
				end
			end

			if (fin) clear_run();
		endfunction

		// Empty string when the result item matches the oldest expectation
		function string check_result(res_t got);
			res_t want;
			if (expected.size() == 0)
				return $sformatf("result with none expected: cnt=%0d na=%0b empty=%0b last=%0b",
					got.cnt, got.na, got.empty, got.last);
			want = expected.pop_front();
			if (got.cnt !== want.cnt || got.na !== want.na || got.empty !== want.empty ||
					got.last !== want.last)
				return $sformatf("got cnt=%0d na=%0b empty=%0b last=%0b, want cnt=%0d na=%0b empty=%0b last=%0b",
					got.cnt, got.na, got.empty, got.last,
					want.cnt, want.na, want.empty, want.last);
			return "";
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [0] sample_missing
	logic        s_axis_tlast = 1'b0; // final_sample
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // [5:0] valid_count
	logic [1:0]  m_axis_tuser;        // [0] result_na, [1] empty_marker
	logic        m_axis_tlast;        // last_result

	window_count_board board;
	int          errors = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	int          stall_left = 0;
	int          rx_mode = 0;
	int          rx_mode_left = 0;
	res_t        seen_res;
	string       mon_msg;

	moving_window_valid_count_core #(
		.MAX_WINDOW(MAX_WINDOW_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#(TIMEOUT);
		$display("tb: failure");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40) $display("tb: mismatch at %0t: %s", $time, msg);
	endtask

	// Receiver: switches between always ready, coin flips and long stalls
	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(20, 200);
		end else begin
			rx_mode_left--;
		end
		if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= $urandom_range(0, 1);
				default: begin
					if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
					m_axis_tready <= (stall_left == 0);
				end
			endcase
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			seen_res.cnt = m_axis_tdata[5:0];
			seen_res.na = m_axis_tuser[0];
			seen_res.empty = m_axis_tuser[1];
			seen_res.last = m_axis_tlast;
			mon_msg = board.check_result(seen_res);
			if (mon_msg != "") report_mismatch(mon_msg);
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		board.set_reg(idx, val);
	endtask

	// Writes every register; unused upper data bits sometimes carry junk
	task automatic apply_config(input logic [5:0] n, input logic [15:0] ss, input bit keep,
			input bit red, input logic [1:0] al);
		logic [15:0] junk;
		junk = $urandom_range(0, 1) ? 16'($urandom) : 16'd0;
		write_reg(REG_WINDOW_SIZE, (junk & 16'hFFC0) | 16'(n));
		write_reg(REG_STEP_SIZE, ss);
		write_reg(REG_REMOVE_MISSING, (junk & 16'hFFFE) | 16'(keep));
		write_reg(REG_REDUCED_OUTPUT, (junk & 16'hFFFE) | 16'(red));
		write_reg(REG_ALIGNMENT, (junk & 16'hFFFC) | 16'(al));
	endtask

	// Sender: bursts of random length with random gaps between them
	task automatic send_sample(input bit miss, input bit fin);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'd0, miss};
		s_axis_tlast <= fin;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		board.note_sample(miss, fin);
		items_sent++;
	endtask

	task automatic send_run(input int len, input int miss_pct, input bit close);
		int k;
		for (k = 0; k < len; k++)
			send_sample($urandom_range(0, 99) < miss_pct, close && k == len - 1);
	endtask

	// Hold the sender until every expected result item is out, then let the pipe settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int start, nvec, v, len, pct, r;
		bit open_run;
		logic [5:0] n;
		logic [15:0] ss;
		board = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset
		send_sample(0, 0);
		send_sample(1, 0);
		send_sample(0, 1);
		drain();

		// middle alignment, counting, step two; spare indexes are ignored
		for (r = REG_COUNT; r < REG_INDEX_SPAN; r++) write_reg(3'(r), 16'($urandom));
		apply_config(6'd4, 16'd2, 1, 0, ALIGN_MIDDLE);
		send_run(7, 40, 1);
		drain();

		// zero window and zero step clamp up, spare alignment acts as right, reduced mode
		apply_config(6'd0, 16'd0, 0, 1, ALIGN_SPARE);
		send_sample(0, 0);
		send_sample(0, 0);
		send_sample(1, 1);
		drain();

		// run shorter than the window in reduced mode gives the empty marker
		apply_config(6'd8, 16'd1, 1, 1, ALIGN_RIGHT);
		send_run(3, 0, 1);
		drain();

		// oversized window clamps to the maximum; short run flushes NA positions
		apply_config(6'd63, 16'd1, 1, 0, ALIGN_LEFT);
		send_run(2, 50, 1);
		drain();

		// config change in the middle of a run
		apply_config(6'd2, 16'd1, 0, 0, ALIGN_LEFT);
		send_sample(0, 0);
		send_sample(1, 0);
		drain();
		write_reg(REG_REMOVE_MISSING, 16'd1);
		write_reg(REG_ALIGNMENT, 16'(ALIGN_MIDDLE));
		send_sample(0, 0);
		send_sample(0, 1);
		drain();

		// widest step
		apply_config(6'd1, 16'hFFFF, 0, 0, ALIGN_LEFT);
		send_run(4, 0, 1);
		drain();

		// random phases
		start = items_sent;
		open_run = 0;
		while (items_sent - start < RANDOM_ITEMS) begin
			drain();
			case ($urandom_range(0, 9))
				0: n = 6'd0;
				1: n = 6'd32;
				2: n = 6'($urandom_range(33, 63));
				3: n = 6'd1;
				default: n = 6'($urandom_range(2, 8));
			endcase
			case ($urandom_range(0, 7))
				0: ss = 16'd0;
				1: ss = 16'hFFFF;
				2: ss = 16'($urandom);
				default: ss = 16'($urandom_range(1, 4));
			endcase
			apply_config(n, ss, $urandom_range(0, 1), $urandom_range(0, 1),
				2'($urandom_range(0, 3)));
			nvec = $urandom_range(1, 3);
			for (v = 0; v < nvec; v++) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
				case ($urandom_range(0, 4))
					0: pct = 0;
					1: pct = 100;
					2: pct = 10;
					3: pct = 50;
					default: pct = $urandom_range(0, 100);
				endcase
				// a run is sometimes left open so the next config lands mid-run
				open_run = (v == nvec - 1) && ($urandom_range(0, 4) == 0);
				send_run(len, pct, !open_run);
			end
		end
		if (open_run) send_sample($urandom_range(0, 1), 1);
		drain();

		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
